@@ hw/rtl/pchft_pkg.sv @@
`default_nettype none

package pchft_pkg;

	localparam int CHAN_BITS  = 3;
	localparam int MASK_BITS  = 8;
	localparam int DELAY_BITS = 16;
	localparam int ADDR_BITS  = 3;
	localparam int DATA_BITS  = 32;

	localparam logic [DELAY_BITS-1:0] HOLD_DELAY_RESET = 16'd250;

	// register index, taken from paddr above the byte offset
	localparam logic REG_HOLD_DELAY = 1'b0;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_START = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t                 cmd;
		logic [CHAN_BITS-1:0] channel;
	} in_t;

	typedef struct packed {
		logic                 deferred;
		logic [MASK_BITS-1:0] flush_mask;
	} out_t;

	// per-beat strobes broadcast to every cell, already qualified by accept
	typedef struct packed {
		logic tick;
		logic start;
		logic query;
	} cell_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/pchft_cell.sv @@
`default_nettype none

module pchft_cell #(
	parameter int COUNT_BITS = 16
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  pchft_pkg::cell_ctrl_t      ctrl,
	input  wire                        sel,
	input  wire  [COUNT_BITS-1:0]      load,
	input  wire                        def_in,
	output logic                       def_out,
	output logic                       flush
);
	import pchft_pkg::*;

	logic                  active_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic                  zero;
	logic                  my_def;

	assign zero    = (rem_q == '0);
	assign flush   = ctrl.tick && active_q && zero;
	assign my_def  = ctrl.query && sel && active_q && !zero;
	// query answer ripples down the row
	assign def_out = def_in | my_def;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			rem_q    <= '0;
		end else begin
			if (ctrl.tick && active_q) begin
				if (zero) begin
					active_q <= 1'b0;
				end else begin
					rem_q <= rem_q - 1'b1;
				end
			end
			if (ctrl.start && sel) begin
				active_q <= 1'b1;
				rem_q    <= load;
			end
			if (ctrl.query && sel && active_q && zero) begin
				active_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/per_channel_holdoff_flush_timer_top.sv @@
`default_nettype none

// channel | direction | handshake           | payload
// cmd     | in        | cmd_valid/cmd_stall | cmd_data   (cmd, channel)
// rsp     | out       | rsp_valid/rsp_stall | rsp_data   (deferred, flush_mask)
// apb     | in/out    | psel/penable/pready | paddr, pwdata, prdata (hold_delay)
//
// one beat per cycle while cmd_stall is low: each command is resolved in the cycle it is accepted
// every beat yields exactly one response beat, registered at the output
// a skid register takes one extra response, so cmd_stall rises only when both
// the output register and the skid register hold results
// arst_n clears every hold and restores hold_delay to 250 ticks
// hold_delay must be written only while the block is idle; the block itself does not enforce this

module per_channel_holdoff_flush_timer_top #(
	parameter int CHANNELS   = 8,
	parameter int COUNT_BITS = 16
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cmd_valid,
	output logic                                  cmd_stall,
	input  pchft_pkg::in_t                        cmd_data,
	output logic                                  rsp_valid,
	input  wire                                   rsp_stall,
	output pchft_pkg::out_t                       rsp_data,
	input  wire                                   psel,
	input  wire                                   penable,
	input  wire                                   pwrite,
	input  wire  [pchft_pkg::ADDR_BITS-1:0]       paddr,
	input  wire  [pchft_pkg::DATA_BITS-1:0]       pwdata,
	output logic [pchft_pkg::DATA_BITS-1:0]       prdata,
	output logic                                  pready
);
	import pchft_pkg::*;

	// configuration register
	logic [DELAY_BITS-1:0] hold_delay_q;
	logic                  cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_delay_q <= HOLD_DELAY_RESET;
		end else if (cfg_wr && (paddr[ADDR_BITS-1] == REG_HOLD_DELAY)) begin
			hold_delay_q <= pwdata[DELAY_BITS-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[ADDR_BITS-1] == REG_HOLD_DELAY) begin
			prdata = {{(DATA_BITS-DELAY_BITS){1'b0}}, hold_delay_q};
		end
	end

	// reload value, saturated to the counter width
	logic [COUNT_BITS-1:0] load;

	generate
		if (COUNT_BITS >= DELAY_BITS) begin : g_load_wide
			assign load = {{(COUNT_BITS-DELAY_BITS){1'b0}}, hold_delay_q};
		end else begin : g_load_sat
			assign load = (hold_delay_q[DELAY_BITS-1:COUNT_BITS] != '0) ?
				{COUNT_BITS{1'b1}} : hold_delay_q[COUNT_BITS-1:0];
		end
	endgenerate

	// input handshake and command decode
	logic       accept;
	logic       skid_valid_q;
	cell_ctrl_t ctrl;

	assign cmd_stall  = skid_valid_q;
	assign accept     = cmd_valid && !cmd_stall;
	assign ctrl.tick  = accept && (cmd_data.cmd == CMD_TICK);
	assign ctrl.start = accept && (cmd_data.cmd == CMD_START);
	assign ctrl.query = accept && (cmd_data.cmd == CMD_QUERY);

	// row of channel cells; the query answer travels along def_chain
	logic [CHANNELS:0]   def_chain;
	logic [CHANNELS-1:0] flush;
	logic [CHANNELS-1:0] sel;

	assign def_chain[0] = 1'b0;

	genvar c;
	generate
		for (c = 0; c < CHANNELS; c++) begin : g_cell
			// channels the 3-bit field cannot reach are never selected
			assign sel[c] = (32'(cmd_data.channel) == c);

			pchft_cell #(
				.COUNT_BITS (COUNT_BITS)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctrl    (ctrl),
				.sel     (sel[c]),
				.load    (load),
				.def_in  (def_chain[c]),
				.def_out (def_chain[c+1]),
				.flush   (flush[c])
			);
		end
	endgenerate

	// only the low eight channels have a mask bit
	out_t res_new;

	assign res_new.deferred = def_chain[CHANNELS];

	generate
		for (c = 0; c < MASK_BITS; c++) begin : g_mask
			if (c < CHANNELS) begin : g_bit
				assign res_new.flush_mask[c] = flush[c];
			end else begin : g_zero
				assign res_new.flush_mask[c] = 1'b0;
			end
		end
	endgenerate

	// output register plus skid register
	logic rsp_valid_q;
	out_t rsp_data_q;
	out_t skid_data_q;
	logic out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				// skid drains first; input is stalled while it is full
				if (skid_valid_q) begin
					rsp_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					rsp_valid_q <= accept;
				end
			end else if (accept) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				rsp_data_q <= skid_data_q;
			end else if (accept) begin
				rsp_data_q <= res_new;
			end
		end else if (accept) begin
			skid_data_q <= res_new;
		end
	end

	// a full skid register always sits behind a full output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> rsp_valid_q)
		else $error("skid holds a beat while output register is empty");

	// a command other than tick never reports a flush
	a_flush_only_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd_data.cmd != CMD_TICK)) |-> (res_new.flush_mask == '0))
		else $error("flush reported on a non-tick command");

	// an accepted beat while the output is stalled lands in the skid register
	a_stall_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && rsp_valid_q && rsp_stall) |=> skid_valid_q)
		else $error("beat lost while output stalled");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import pchft_pkg::*;

	localparam int NUM_CHAN = 8;
	localparam int COUNT_W  = 16;
	// byte address of hold_delay: register index above the 2-bit byte offset
	localparam logic [ADDR_BITS-1:0] HOLD_DELAY_ADDR = {REG_HOLD_DELAY, 2'b00};
	localparam int IDLE_PCT   = 31;
	localparam int DRAIN_WAIT = 4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 cmd_valid = 1'b0;
	logic                 cmd_stall;
	in_t                  cmd_data = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	out_t                 rsp_data;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_BITS-1:0] paddr = '0;
	logic [DATA_BITS-1:0] pwdata = '0;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;

	// shadow of the hold timer, kept in step with accepted command beats
	logic [DELAY_BITS-1:0] shadow_delay = HOLD_DELAY_RESET;
	logic                  shadow_armed [NUM_CHAN];
	logic [COUNT_W-1:0]    shadow_left [NUM_CHAN];

	// answers still owed by the block, oldest first
	out_t expected_answers[$];
	int   mismatches = 0;
	// when set, neither side inserts gaps or stalls
	bit   no_gaps = 1'b0;

	per_channel_holdoff_flush_timer_top #(
		.CHANNELS  (NUM_CHAN),
		.COUNT_BITS(COUNT_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_data (cmd_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data (rsp_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// hard stop in case a handshake never completes
	initial begin
		#5_000_000;
		$display("per_channel_holdoff_flush_timer_top test failed");
		$finish;
	end

	// work out the answer to one command and advance the shadow holds
	function automatic out_t hold_timer_step(cmd_t op, logic [CHAN_BITS-1:0] ch);
		out_t ans;
		ans = '0;
		case (op)
			CMD_TICK: begin
				for (int c = 0; c < NUM_CHAN; c++) begin
					if (shadow_armed[c]) begin
						// a count already at zero is flushed, otherwise it counts down
						if (shadow_left[c] == '0) begin
							shadow_armed[c] = 1'b0;
							if (c < MASK_BITS)
								ans.flush_mask[c] = 1'b1;
						end else begin
							shadow_left[c] = shadow_left[c] - 1'b1;
						end
					end
				end
			end
			CMD_START: begin
				// latest start wins: reload the count
				if (ch < NUM_CHAN) begin
					shadow_armed[ch] = 1'b1;
					shadow_left[ch]  = shadow_delay;
				end
			end
			CMD_QUERY: begin
				// a run-out hold is cleared by the query and not deferred
				if (ch < NUM_CHAN && shadow_armed[ch]) begin
					if (shadow_left[ch] == '0)
						shadow_armed[ch] = 1'b0;
					else
						ans.deferred = 1'b1;
				end
			end
			default: ;
		endcase
		return ans;
	endfunction

	// receiver: random stall, changed only at the rising edge
	always @(posedge clk) begin
		rsp_stall <= !no_gaps && ($urandom_range(99) < IDLE_PCT);
	end

	// response checker: a beat seen at the falling edge completes at the next rising edge
	always @(negedge clk) begin
		out_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_answers.size() == 0) begin
				mismatches++;
				$display("%0t: response beat with nothing expected, got deferred=%0b mask=%02h",
					$time, rsp_data.deferred, rsp_data.flush_mask);
			end else begin
				want = expected_answers.pop_front();
				if (rsp_data.deferred !== want.deferred) begin
					mismatches++;
					$display("%0t: deferred mismatch, expected %0b, actual %0b",
						$time, want.deferred, rsp_data.deferred);
				end
				if (rsp_data.flush_mask !== want.flush_mask) begin
					mismatches++;
					$display("%0t: flush_mask mismatch, expected %02h, actual %02h",
						$time, want.flush_mask, rsp_data.flush_mask);
				end
			end
		end
	end

	// send one command beat; called and returns at a rising edge
	task automatic send_beat(cmd_t op, logic [CHAN_BITS-1:0] ch);
		// each cycle idles on its own draw, so idle cycles stay near IDLE_PCT
		if (!no_gaps) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				cmd_valid <= 1'b0;
				@(posedge clk);
			end
		end
		cmd_valid <= 1'b1;
		cmd_data  <= '{cmd: op, channel: ch};
		@(negedge clk);
		while (cmd_stall) @(negedge clk);
		expected_answers.push_back(hold_timer_step(op, ch));
		@(posedge clk);
	endtask

	// stop sending and wait for every owed answer, then let the pipeline settle
	task automatic drain;
		int waited;
		waited = 0;
		cmd_valid <= 1'b0;
		while (expected_answers.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		if (expected_answers.size() != 0) begin
			mismatches++;
			$display("%0t: %0d answers never arrived, expected deferred=%0b mask=%02h",
				$time, expected_answers.size(), expected_answers[0].deferred,
				expected_answers[0].flush_mask);
			expected_answers.delete();
		end
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// apb write of hold_delay: setup cycle, then access cycle
	task automatic write_hold_delay(logic [DELAY_BITS-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= HOLD_DELAY_ADDR;
		pwdata  <= DATA_BITS'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		@(posedge clk);
		shadow_delay = value;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// apb read of hold_delay, compared in the access cycle
	task automatic check_hold_delay_read;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= HOLD_DELAY_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		if (prdata !== DATA_BITS'(shadow_delay)) begin
			mismatches++;
			$display("%0t: hold_delay read mismatch, expected %0d, actual %0d",
				$time, shadow_delay, prdata);
		end
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic test_register_access;
		check_hold_delay_read();
		write_hold_delay(16'hA5C3);
		check_hold_delay_read();
		write_hold_delay(16'h5A3C);
		check_hold_delay_read();
	endtask

	task automatic test_directed;
		// zero delay: query idle, arm every channel, query clears one, tick flushes the rest
		write_hold_delay('0);
		send_beat(CMD_QUERY, 3'd0);
		for (int c = 0; c < NUM_CHAN; c++)
			send_beat(CMD_START, CHAN_BITS'(c));
		send_beat(CMD_QUERY, 3'd2);
		send_beat(CMD_QUERY, 3'd2);
		send_beat(CMD_TICK, 3'd7);
		send_beat(CMD_TICK, 3'd0);
		drain();
		// short hold with a restart that wins over the first start
		write_hold_delay(16'd2);
		send_beat(CMD_START, 3'd3);
		send_beat(CMD_START, 3'd5);
		send_beat(CMD_QUERY, 3'd3);
		send_beat(CMD_TICK, 3'd1);
		send_beat(CMD_START, 3'd5);
		send_beat(CMD_TICK, 3'd6);
		send_beat(CMD_TICK, 3'd2);
		send_beat(CMD_NOP, 3'd5);
		drain();
		// longest hold stays deferred across a tick
		write_hold_delay(16'hFFFF);
		check_hold_delay_read();
		send_beat(CMD_START, 3'd1);
		send_beat(CMD_TICK, 3'd4);
		send_beat(CMD_QUERY, 3'd1);
		drain();
	endtask

	// weighted random commands; ticks and queries dominate so holds both run out and get cleared
	task automatic run_random_phase(logic [DELAY_BITS-1:0] delay, int beats);
		int   pick;
		cmd_t op;
		write_hold_delay(delay);
		for (int i = 0; i < beats; i++) begin
			pick = $urandom_range(99);
			if (pick < 40)
				op = CMD_TICK;
			else if (pick < 62)
				op = CMD_START;
			else if (pick < 92)
				op = CMD_QUERY;
			else
				op = CMD_NOP;
			send_beat(op, CHAN_BITS'($urandom_range(NUM_CHAN - 1)));
		end
		drain();
	endtask

	task automatic test_random;
		run_random_phase('0, 150);
		run_random_phase(16'd1, 200);
		run_random_phase(16'd3, 200);
		run_random_phase(DELAY_BITS'($urandom_range(2, 12)), 200);
		run_random_phase(16'hFFFF, 60);
	endtask

	// back to back beats with the receiver never stalling
	task automatic test_no_gaps;
		no_gaps = 1'b1;
		run_random_phase(16'd2, 200);
		no_gaps = 1'b0;
	endtask

	initial begin
		for (int c = 0; c < NUM_CHAN; c++) begin
			shadow_armed[c] = 1'b0;
			shadow_left[c]  = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_access();
		test_directed();
		test_random();
		test_no_gaps();

		drain();
		if (mismatches == 0)
			$display("per_channel_holdoff_flush_timer_top test passed");
		else
			$display("per_channel_holdoff_flush_timer_top test failed");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/pchft_pkg.sv
hw/rtl/pchft_cell.sv
hw/rtl/per_channel_holdoff_flush_timer_top.sv
tb/testbench.sv
